[sv/lbce_pkg.sv]
// ----------------------------------------------------------------------------
// lbce_pkg
// Types, constants and bit-scan helpers for the lamp bitfield command engine.
// ----------------------------------------------------------------------------
package lbce_pkg;

  localparam int MapW       = 32;  // lamps per map
  localparam int WingW      = 8;   // lamps per wing port
  localparam int MaxWings   = 4;   // wings that fit in one map
  localparam int NumWings   = 4;   // wings fitted on this board (1 to 4)
  localparam int ScanLevels = 5;   // log2 of MapW
  localparam int ActionW    = 4;
  localparam int InDataW    = 40;  // 37 payload bits rounded up to bytes
  localparam int OutDataW   = 40;  // 36 payload bits rounded up to bytes
  localparam int CfgIndexW  = 2;
  localparam int CfgDataW   = 4;

  typedef logic [MapW-1:0]     map_t;
  typedef logic [MaxWings-1:0] wing_mask_t;

  typedef enum logic [ActionW-1:0] {
    ACT_ROTL     = 4'd0,
    ACT_ROTR     = 4'd1,
    ACT_ON       = 4'd2,
    ACT_OFF      = 4'd3,
    ACT_SLOW     = 4'd4,
    ACT_FAST     = 4'd5,
    ACT_BLINKOFF = 4'd6,
    ACT_SETALL   = 4'd7,
    ACT_COMBINED = 4'd8,
    ACT_TICK     = 4'd9,
    ACT_INIT     = 4'd10
  } action_t;

  typedef enum logic [CfgIndexW-1:0] {
    CFG_ENABLE      = 2'd0,
    CFG_WING_VALID  = 2'd1,
    CFG_WING_INVERT = 2'd2
  } cfg_index_t;

  // Result of a prefix scan: v marks that some mask bit at or below the
  // position exists, d carries the on bit of the highest such mask bit.
  typedef struct packed {
    map_t v;
    map_t d;
  } scan_t;

  // Wings that exist on the board.
  function automatic wing_mask_t wing_limit();
    wing_mask_t m;
    m = '0;
    for (int w = 0; w < MaxWings; w++) begin
      if (w < NumWings) m[w] = 1'b1;
    end
    return m;
  endfunction

  // Inclusive log-depth prefix scan; a higher valid element overrides.
  function automatic scan_t prefix_scan(map_t v_in, map_t d_in);
    scan_t s;
    scan_t n;
    s.v = v_in;
    s.d = d_in;
    for (int l = 0; l < ScanLevels; l++) begin
      n = s;
      for (int i = 0; i < MapW; i++) begin
        if (i >= (1 << l)) begin
          n.v[i] = s.v[i] | s.v[i - (1 << l)];
          n.d[i] = s.v[i] ? s.d[i] : s.d[i - (1 << l)];
        end
      end
      s = n;
    end
    return s;
  endfunction

  // Each on bit at a mask position moves to the next higher mask position;
  // the highest one wraps around to the lowest.
  function automatic map_t masked_rotl(map_t on_bits, map_t mask);
    scan_t s;
    map_t  res;
    s = prefix_scan(mask, on_bits);
    res = on_bits;
    for (int i = 0; i < MapW; i++) begin
      if (mask[i]) begin
        if (i > 0 && s.v[(i > 0) ? i - 1 : 0]) res[i] = s.d[(i > 0) ? i - 1 : 0];
        else res[i] = s.d[MapW-1];
      end
    end
    return res;
  endfunction

  function automatic map_t bit_reverse(map_t x);
    map_t r;
    for (int i = 0; i < MapW; i++) begin
      r[i] = x[MapW-1-i];
    end
    return r;
  endfunction

  // Mirror image of masked_rotl.
  function automatic map_t masked_rotr(map_t on_bits, map_t mask);
    return bit_reverse(masked_rotl(bit_reverse(on_bits), bit_reverse(mask)));
  endfunction

endpackage

[sv/lamp_bitfield_command_engine_unit.sv]
// ----------------------------------------------------------------------------
// lamp_bitfield_command_engine_unit
// Keeps the on, slow-blink and fast-blink maps of 32 lamps on four wing ports,
// applies lamp commands to them and answers tick requests with a drive word.
// ----------------------------------------------------------------------------
//
//   Channel  Direction  Handshake         Payload
//   -------  ---------  ----------------  ---------------------------------------
//   s_*      in         tvalid / tready   tuser action, tdata mask and flags
//   m_*      out        tvalid / tready   tdata lamp drive and wing write enables
//   cfg_*    in         cfg_we only       register index and write data
//
// One request is taken per clock while s_tready is high. A request is first
// captured in an input register and applied to the maps when it leaves that
// register; at that same edge a tick's drive word is loaded into the output
// register, which raises m_tvalid. Only ticks with the block enabled give a
// result.
// Reset (rst, synchronous) clears the maps, the configuration registers and both valid flags.
// When m_tready is low the result holds; a tick waiting behind it holds in the
// input register and s_tready drops, while other commands keep flowing.
//
module lamp_bitfield_command_engine_unit
  import lbce_pkg::*;
(
  input  logic                 clk,
  input  logic                 rst,
  // Request stream.
  input  logic                 s_tvalid,
  output logic                 s_tready,
  input  logic [InDataW-1:0]   s_tdata,   // lamp_mask[31:0], combined_on[32],
                                          // combined_slow[33], combined_fast[34],
                                          // slow_phase_on[35], fast_phase_on[36],
                                          // zero [39:37]
  input  logic [ActionW-1:0]   s_tuser,   // action[3:0]
  // Result stream.
  output logic                 m_tvalid,
  input  logic                 m_tready,
  output logic [OutDataW-1:0]  m_tdata,   // lamp_drive[31:0],
                                          // wing_write_enable[35:32], zero [39:36]
  // Configuration writes.
  input  logic                 cfg_we,
  input  logic [CfgIndexW-1:0] cfg_index,
  input  logic [CfgDataW-1:0]  cfg_data
);

  // Configuration registers.
  logic       enable;
  wing_mask_t wing_valid_mask;
  wing_mask_t wing_invert_mask;

  // Lamp maps.
  map_t on_map, on_map_next;
  map_t slow_map, slow_map_next;
  map_t fast_map, fast_map_next;

  // Input register holding one request.
  logic    stage_valid;
  action_t stage_action;
  map_t    stage_mask;
  logic    stage_c_on, stage_c_slow, stage_c_fast;
  logic    stage_slow_ph, stage_fast_ph;

  // Output register.
  map_t       lamp_drive;
  wing_mask_t wing_write_enable;

  logic       produce;
  logic       stage_fire;
  wing_mask_t valid_wings;
  map_t       lit;
  map_t       drive_calc;

  always_ff @(posedge clk) begin
    if (rst) begin
      enable           <= 1'b0;
      wing_valid_mask  <= '0;
      wing_invert_mask <= '0;
    end else if (cfg_we) begin
      case (cfg_index)
        CFG_ENABLE:      enable           <= cfg_data[0];
        CFG_WING_VALID:  wing_valid_mask  <= cfg_data;
        CFG_WING_INVERT: wing_invert_mask <= cfg_data;
        default: ;
      endcase
    end
  end

  // Only an enabled tick produces a result, and it can leave the input
  // register only when the output register is free or being emptied.
  assign produce    = stage_valid && (stage_action == ACT_TICK) && enable;
  assign stage_fire = stage_valid && (!produce || !m_tvalid || m_tready);
  assign s_tready   = !stage_valid || stage_fire;

  always_ff @(posedge clk) begin
    if (rst) begin
      stage_valid <= 1'b0;
    end else if (s_tready) begin
      stage_valid <= s_tvalid;
    end
  end

  always_ff @(posedge clk) begin
    if (s_tvalid && s_tready) begin
      stage_action  <= action_t'(s_tuser);
      stage_mask    <= s_tdata[MapW-1:0];
      stage_c_on    <= s_tdata[MapW];
      stage_c_slow  <= s_tdata[MapW+1];
      stage_c_fast  <= s_tdata[MapW+2];
      stage_slow_ph <= s_tdata[MapW+3];
      stage_fast_ph <= s_tdata[MapW+4];
    end
  end

  assign valid_wings = wing_valid_mask & wing_limit();

  // Map updates for each command.
  always_comb begin
    on_map_next   = on_map;
    slow_map_next = slow_map;
    fast_map_next = fast_map;
    case (stage_action)
      ACT_ROTL: on_map_next = masked_rotl(on_map, stage_mask);
      ACT_ROTR: on_map_next = masked_rotr(on_map, stage_mask);
      ACT_ON:   on_map_next = on_map | stage_mask;
      ACT_OFF:  on_map_next = on_map & ~stage_mask;
      ACT_SLOW: begin
        slow_map_next = slow_map | stage_mask;
        fast_map_next = fast_map & ~stage_mask;
      end
      ACT_FAST: begin
        fast_map_next = fast_map | stage_mask;
        slow_map_next = slow_map & ~stage_mask;
      end
      ACT_BLINKOFF: begin
        slow_map_next = slow_map & ~stage_mask;
        fast_map_next = fast_map & ~stage_mask;
      end
      ACT_SETALL: begin
        on_map_next   = stage_mask;
        slow_map_next = '0;
        fast_map_next = '0;
      end
      ACT_COMBINED: begin
        on_map_next = stage_c_on ? (on_map | stage_mask) : (on_map & ~stage_mask);
        // Slow wins over fast; with neither flag both blinks are cleared.
        if (stage_c_slow) begin
          slow_map_next = slow_map | stage_mask;
          fast_map_next = fast_map & ~stage_mask;
        end else if (stage_c_fast) begin
          fast_map_next = fast_map | stage_mask;
          slow_map_next = slow_map & ~stage_mask;
        end else begin
          slow_map_next = slow_map & ~stage_mask;
          fast_map_next = fast_map & ~stage_mask;
        end
      end
      ACT_INIT: begin
        // Every valid wing starts out blinking slowly.
        on_map_next   = '0;
        fast_map_next = '0;
        for (int w = 0; w < MaxWings; w++) begin
          slow_map_next[w*WingW +: WingW] = {WingW{valid_wings[w]}};
        end
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      on_map   <= '0;
      slow_map <= '0;
      fast_map <= '0;
    end else if (stage_fire) begin
      on_map   <= on_map_next;
      slow_map <= slow_map_next;
      fast_map <= fast_map_next;
    end
  end

  // Tick: light the on lamps plus each blink map in its lit phase, then
  // blank invalid wings and invert high-side wings byte by byte.
  always_comb begin
    lit = on_map | (stage_slow_ph ? slow_map : '0) | (stage_fast_ph ? fast_map : '0);
    for (int w = 0; w < MaxWings; w++) begin
      if (!valid_wings[w]) begin
        drive_calc[w*WingW +: WingW] = '0;
      end else if (wing_invert_mask[w]) begin
        drive_calc[w*WingW +: WingW] = ~lit[w*WingW +: WingW];
      end else begin
        drive_calc[w*WingW +: WingW] = lit[w*WingW +: WingW];
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      m_tvalid <= 1'b0;
    end else if (stage_fire && produce) begin
      m_tvalid <= 1'b1;
    end else if (m_tready) begin
      m_tvalid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (stage_fire && produce) begin
      lamp_drive        <= drive_calc;
      wing_write_enable <= valid_wings;
    end
  end

  assign m_tdata = {{(OutDataW - MapW - MaxWings){1'b0}}, wing_write_enable, lamp_drive};

endmodule

[tb/lamp_bitfield_command_engine_unit_tb.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// lamp_bitfield_command_engine_unit_tb
// Self-checking bench for the lamp command engine. A clocked driver sends
// lamp commands and ticks in bursts, a clocked monitor takes the drive words
// under its own stall pattern, and a local model of the three lamp maps works
// out every drive word that must come back.
// ----------------------------------------------------------------------------
module lamp_bitfield_command_engine_unit_tb;
  import lbce_pkg::*;

  localparam int SettleCycles = 6;          // covers the tick path through the input and output registers
  localparam int TimeoutNs    = 2_000_000;  // far beyond the slowest good run

  // The action field also carries the unused codes above ACT_INIT.
  localparam logic [ActionW-1:0] ActUnusedLo = ActionW'(ACT_INIT + 1);
  localparam logic [ActionW-1:0] ActUnusedHi = '1;

  // One lamp request as it travels on the slave stream.
  typedef struct packed {
    logic [ActionW-1:0] action;
    map_t               lamp_mask;
    logic               comb_on;
    logic               comb_slow;
    logic               comb_fast;
    logic               slow_lit;
    logic               fast_lit;
  } lamp_req_t;

  // One drive word as it must appear on the master stream.
  typedef struct {
    map_t       drive;
    wing_mask_t wing_we;
  } drive_word_t;

  logic                 clk = 1'b0;
  logic                 rst = 1'b1;
  logic                 s_tvalid = 1'b0;
  logic                 s_tready;
  logic [InDataW-1:0]   s_tdata = '0;
  logic [ActionW-1:0]   s_tuser = '0;
  logic                 m_tvalid;
  logic                 m_tready = 1'b0;
  logic [OutDataW-1:0]  m_tdata;
  logic                 cfg_we = 1'b0;
  cfg_index_t           cfg_index = CFG_ENABLE;
  logic [CfgDataW-1:0]  cfg_data = '0;

  lamp_bitfield_command_engine_unit dut (
    .clk       (clk),
    .rst       (rst),
    .s_tvalid  (s_tvalid),
    .s_tready  (s_tready),
    .s_tdata   (s_tdata),
    .s_tuser   (s_tuser),
    .m_tvalid  (m_tvalid),
    .m_tready  (m_tready),
    .m_tdata   (m_tdata),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data)
  );

  always begin
    #2 clk = 1'b1;
    #2 clk = 1'b0;
  end

  // --------------------------------------------------------------------------
  // Local copy of the engine: the three lamp maps and the three registers.
  // Registers only change while the engine is idle, so the driver can read
  // them at acceptance time without racing the write.
  // --------------------------------------------------------------------------
  map_t       lamps_on   = '0;
  map_t       lamps_slow = '0;
  map_t       lamps_fast = '0;
  logic       cfg_enable = 1'b0;
  wing_mask_t cfg_wings  = '0;
  wing_mask_t cfg_invert = '0;

  lamp_req_t   pending_requests[$];   // filled by the sequence, drained by the driver
  drive_word_t drive_words_due[$];    // drive words still owed by the engine

  int mismatch_count = 0;
  int requests_sent  = 0;
  int words_checked  = 0;
  int settings_used  = 0;

  task automatic report_mismatch(string msg);
    $display("[%0t] MISMATCH: %s", $time, msg);
    mismatch_count++;
  endtask

  // Moves each lit bit at a selected position to the next selected position,
  // toward the MSB or the LSB, with the end position wrapping around.
  function automatic map_t shift_among_mask(map_t bits, map_t sel, bit toward_msb);
    int   pos[MapW];
    int   n;
    map_t res;
    n   = 0;
    res = bits;
    for (int i = 0; i < MapW; i++) begin
      if (sel[i]) begin
        pos[n] = i;
        n++;
      end
    end
    for (int k = 0; k < n; k++) begin
      if (toward_msb) res[pos[k]] = bits[pos[(k + n - 1) % n]];
      else res[pos[k]] = bits[pos[(k + 1) % n]];
    end
    return res;
  endfunction

  // Applies one accepted request to the maps and, for an enabled tick,
  // queues the drive word that the engine owes.
  task automatic apply_request(lamp_req_t r);
    map_t             lit;
    wing_mask_t       live;
    logic [WingW-1:0] lamp_byte;
    drive_word_t      word;
    // A wing drives only when it is marked valid and is actually fitted.
    live = '0;
    for (int w = 0; w < MaxWings; w++) begin
      if (w < NumWings) live[w] = cfg_wings[w];
    end
    case (r.action)
      ACT_ROTL:     lamps_on = shift_among_mask(lamps_on, r.lamp_mask, 1'b1);
      ACT_ROTR:     lamps_on = shift_among_mask(lamps_on, r.lamp_mask, 1'b0);
      ACT_ON:       lamps_on = lamps_on | r.lamp_mask;
      ACT_OFF:      lamps_on = lamps_on & ~r.lamp_mask;
      ACT_SLOW: begin
        lamps_slow = lamps_slow | r.lamp_mask;
        lamps_fast = lamps_fast & ~r.lamp_mask;
      end
      ACT_FAST: begin
        lamps_fast = lamps_fast | r.lamp_mask;
        lamps_slow = lamps_slow & ~r.lamp_mask;
      end
      ACT_BLINKOFF: begin
        lamps_slow = lamps_slow & ~r.lamp_mask;
        lamps_fast = lamps_fast & ~r.lamp_mask;
      end
      ACT_SETALL: begin
        lamps_on   = r.lamp_mask;
        lamps_slow = '0;
        lamps_fast = '0;
      end
      ACT_COMBINED: begin
        if (r.comb_on) lamps_on = lamps_on | r.lamp_mask;
        else lamps_on = lamps_on & ~r.lamp_mask;
        // Slow wins over fast; with neither flag both blink bits clear.
        if (r.comb_slow) begin
          lamps_slow = lamps_slow | r.lamp_mask;
          lamps_fast = lamps_fast & ~r.lamp_mask;
        end else if (r.comb_fast) begin
          lamps_fast = lamps_fast | r.lamp_mask;
          lamps_slow = lamps_slow & ~r.lamp_mask;
        end else begin
          lamps_slow = lamps_slow & ~r.lamp_mask;
          lamps_fast = lamps_fast & ~r.lamp_mask;
        end
      end
      ACT_TICK: begin
        if (cfg_enable) begin
          lit = lamps_on;
          if (r.slow_lit) lit = lit | lamps_slow;
          if (r.fast_lit) lit = lit | lamps_fast;
          word.drive   = '0;
          word.wing_we = live;
          for (int w = 0; w < MaxWings; w++) begin
            if (live[w]) begin
              lamp_byte = lit[w*WingW +: WingW];
              if (cfg_invert[w]) lamp_byte = ~lamp_byte;
              word.drive[w*WingW +: WingW] = lamp_byte;
            end
          end
          drive_words_due.push_back(word);
        end
      end
      ACT_INIT: begin
        // Every live wing starts out blinking slowly, nothing else is lit.
        lamps_on   = '0;
        lamps_fast = '0;
        lamps_slow = '0;
        for (int w = 0; w < MaxWings; w++) begin
          if (live[w]) lamps_slow[w*WingW +: WingW] = '1;
        end
      end
      default: ;  // unused action codes leave the engine untouched
    endcase
  endtask

  // --------------------------------------------------------------------------
  // Driver. A request stays on the bus until the engine takes it. After each
  // burst of random length the driver leaves a random gap, and sometimes no
  // gap at all, so that long back-to-back runs also occur.
  // --------------------------------------------------------------------------
  lamp_req_t on_bus = '0;
  logic      bus_busy;
  int        burst_left = 0;
  int        gap_left = 0;

  always @(posedge clk) begin
    if (rst) begin
      s_tvalid   <= 1'b0;
      burst_left = 0;
      gap_left   = 0;
    end else begin
      bus_busy = s_tvalid;
      if (s_tvalid && s_tready) begin
        apply_request(on_bus);
        requests_sent++;
        bus_busy = 1'b0;
      end
      if (!bus_busy) begin
        if (gap_left > 0) begin
          gap_left--;
        end else if (pending_requests.size() > 0) begin
          on_bus   = pending_requests.pop_front();
          bus_busy = 1'b1;
          if (burst_left > 0) burst_left--;
          if (burst_left == 0) begin
            burst_left = $urandom_range(1, 24);
            gap_left   = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 8);
          end
        end
      end
      s_tvalid <= bus_busy;
      // Zero pad, fast_lit, slow_lit, comb_fast, comb_slow, comb_on, mask.
      s_tdata  <= {3'b000, on_bus.fast_lit, on_bus.slow_lit, on_bus.comb_fast,
                   on_bus.comb_slow, on_bus.comb_on, on_bus.lamp_mask};
      s_tuser  <= on_bus.action;
    end
  end

  // --------------------------------------------------------------------------
  // Monitor. Every accepted drive word is checked against the oldest one due.
  // The ready line changes mode every so often: always ready, randomly ready,
  // or ready with occasional long stalls.
  // --------------------------------------------------------------------------
  drive_word_t due;
  int          stall_left = 0;
  int          ready_mode = 0;
  int          mode_cycles = 0;

  always @(posedge clk) begin
    if (rst) begin
      m_tready   <= 1'b0;
      stall_left = 0;
    end else begin
      if (m_tvalid && m_tready) begin
        if (drive_words_due.size() == 0) begin
          report_mismatch($sformatf("drive word %h arrived with none due", m_tdata));
        end else begin
          due = drive_words_due.pop_front();
          if (m_tdata[MapW-1:0] !== due.drive)
            report_mismatch($sformatf("lamp_drive %h, expected %h",
                                      m_tdata[MapW-1:0], due.drive));
          if (m_tdata[MapW +: MaxWings] !== due.wing_we)
            report_mismatch($sformatf("wing_write_enable %b, expected %b",
                                      m_tdata[MapW +: MaxWings], due.wing_we));
          words_checked++;
        end
      end

      if (mode_cycles == 0) begin
        ready_mode  = $urandom_range(0, 2);
        mode_cycles = $urandom_range(20, 80);
      end else begin
        mode_cycles--;
      end

      if (stall_left > 0) begin
        stall_left--;
        m_tready <= 1'b0;
      end else if (ready_mode == 0) begin
        m_tready <= 1'b1;
      end else if (ready_mode == 1) begin
        m_tready <= ($urandom_range(0, 3) != 0);
      end else begin
        if ($urandom_range(0, 5) == 0) stall_left = $urandom_range(1, 12);
        m_tready <= 1'b1;
      end
    end
  end

  // --------------------------------------------------------------------------
  // Sequence helpers.
  // --------------------------------------------------------------------------
  task automatic write_reg(cfg_index_t idx, logic [CfgDataW-1:0] val);
    @(posedge clk);
    cfg_we    <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= val;
    case (idx)
      CFG_ENABLE:      cfg_enable = val[0];
      CFG_WING_VALID:  cfg_wings  = val[MaxWings-1:0];
      CFG_WING_INVERT: cfg_invert = val[MaxWings-1:0];
      default: ;
    endcase
    @(posedge clk);
    cfg_we <= 1'b0;
  endtask

  // The upper bits of the enable write are junk that the engine must ignore.
  task automatic set_registers(logic en, wing_mask_t valid, wing_mask_t inv);
    write_reg(CFG_ENABLE, {3'($urandom), en});
    write_reg(CFG_WING_VALID, valid);
    write_reg(CFG_WING_INVERT, inv);
    settings_used++;
  endtask

  // Holds off until every queued request is taken and every drive word has
  // come back, then lets the last commands work through the engine.
  task automatic wait_until_drained();
    @(negedge clk);
    while (pending_requests.size() != 0 || s_tvalid || drive_words_due.size() != 0)
      @(negedge clk);
    repeat (SettleCycles) @(negedge clk);
  endtask

  task automatic queue_request(logic [ActionW-1:0] act, map_t mask, logic c_on,
                               logic c_slow, logic c_fast, logic s_lit, logic f_lit);
    lamp_req_t r;
    r.action    = act;
    r.lamp_mask = mask;
    r.comb_on   = c_on;
    r.comb_slow = c_slow;
    r.comb_fast = c_fast;
    r.slow_lit  = s_lit;
    r.fast_lit  = f_lit;
    pending_requests.push_back(r);
  endtask

  // Masks lean toward the shapes that matter to the rotates and to the wings:
  // empty, full, one bit, one whole wing, a few scattered bits, or anything.
  function automatic map_t random_lamp_mask();
    map_t m;
    case ($urandom_range(0, 7))
      0: m = '0;
      1: m = '1;
      2: m = map_t'(1) << $urandom_range(0, MapW-1);
      3: m = map_t'({WingW{1'b1}}) << (WingW * $urandom_range(0, MaxWings-1));
      4: begin
        m = '0;
        repeat ($urandom_range(2, 4)) m[$urandom_range(0, MapW-1)] = 1'b1;
      end
      default: m = $urandom;
    endcase
    return m;
  endfunction

  function automatic lamp_req_t random_request();
    lamp_req_t r;
    int        pick;
    r.lamp_mask = random_lamp_mask();
    {r.comb_on, r.comb_slow, r.comb_fast, r.slow_lit, r.fast_lit} = 5'($urandom);
    pick = $urandom_range(0, 99);
    if (pick < 25) r.action = ACT_TICK;
    else if (pick < 35) r.action = ACT_ROTL;
    else if (pick < 45) r.action = ACT_ROTR;
    else if (pick < 52) r.action = ACT_ON;
    else if (pick < 59) r.action = ACT_OFF;
    else if (pick < 65) r.action = ACT_SLOW;
    else if (pick < 71) r.action = ACT_FAST;
    else if (pick < 76) r.action = ACT_BLINKOFF;
    else if (pick < 82) r.action = ACT_SETALL;
    else if (pick < 92) r.action = ACT_COMBINED;
    else if (pick < 96) r.action = ACT_INIT;
    else r.action = ActionW'($urandom_range(ActUnusedLo, ActUnusedHi));
    return r;
  endfunction

  // Each phase runs under one register setting. Halfway through, the sender
  // stops until all drive words have returned, then carries on.
  task automatic run_phase(logic en, wing_mask_t valid, wing_mask_t inv, int n);
    set_registers(en, valid, inv);
    repeat (n / 2) pending_requests.push_back(random_request());
    wait_until_drained();
    repeat (n - n / 2) pending_requests.push_back(random_request());
    wait_until_drained();
  endtask

  // --------------------------------------------------------------------------
  // Main sequence.
  // --------------------------------------------------------------------------
  initial begin
    repeat (8) @(posedge clk);
    rst <= 1'b0;

    // Reset values: ticks are dropped while disabled, and an init with no
    // valid wing leaves all three maps empty.
    set_registers(1'b0, '0, '0);
    queue_request(ACT_SETALL, '1, 1'b1, 1'b1, 1'b1, 1'b1, 1'b1);
    queue_request(ACT_TICK, '0, 1'b0, 1'b0, 1'b0, 1'b1, 1'b1);
    queue_request(ACT_INIT, '0, 1'b0, 1'b0, 1'b0, 1'b0, 1'b0);
    queue_request(ActUnusedLo, '1, 1'b1, 1'b1, 1'b1, 1'b1, 1'b1);
    wait_until_drained();

    // Directed cases with all wings live and low-side drive.
    set_registers(1'b1, '1, '0);
    queue_request(ACT_SETALL, 32'h8000_0001, 1'b0, 1'b0, 1'b0, 1'b0, 1'b0);
    queue_request(ACT_TICK, '0, 1'b0, 1'b0, 1'b0, 1'b0, 1'b0);
    // Full-width rotates: the top bit wraps to bit zero and back again.
    queue_request(ACT_ROTL, '1, 1'b0, 1'b0, 1'b0, 1'b0, 1'b0);
    queue_request(ACT_TICK, '0, 1'b0, 1'b0, 1'b0, 1'b0, 1'b0);
    queue_request(ACT_ROTR, '1, 1'b0, 1'b0, 1'b0, 1'b0, 1'b0);
    // Empty mask and one-bit mask leave the on map as it is.
    queue_request(ACT_ROTL, '0, 1'b0, 1'b0, 1'b0, 1'b0, 1'b0);
    queue_request(ACT_ROTL, 32'h0000_0100, 1'b0, 1'b0, 1'b0, 1'b0, 1'b0);
    queue_request(ACT_ROTR, 32'h8421_1249, 1'b0, 1'b0, 1'b0, 1'b0, 1'b0);
    queue_request(ACT_TICK, '0, 1'b0, 1'b0, 1'b0, 1'b0, 1'b0);
    queue_request(ACT_ON, 32'hFFFF_0000, 1'b0, 1'b0, 1'b0, 1'b0, 1'b0);
    queue_request(ACT_OFF, 32'h0F0F_0F0F, 1'b0, 1'b0, 1'b0, 1'b0, 1'b0);
    queue_request(ACT_SLOW, 32'h0000_FFFF, 1'b0, 1'b0, 1'b0, 1'b0, 1'b0);
    queue_request(ACT_FAST, 32'h00FF_FF00, 1'b0, 1'b0, 1'b0, 1'b0, 1'b0);
    queue_request(ACT_TICK, '0, 1'b0, 1'b0, 1'b0, 1'b1, 1'b0);
    queue_request(ACT_TICK, '0, 1'b0, 1'b0, 1'b0, 1'b0, 1'b1);
    queue_request(ACT_BLINKOFF, 32'h0000_0F00, 1'b0, 1'b0, 1'b0, 1'b0, 1'b0);
    queue_request(ACT_TICK, '0, 1'b0, 1'b0, 1'b0, 1'b1, 1'b1);
    // Combined: slow beats fast, fast alone, and neither flag.
    queue_request(ACT_COMBINED, 32'hF0F0_F0F0, 1'b1, 1'b1, 1'b1, 1'b0, 1'b0);
    queue_request(ACT_COMBINED, 32'h0F0F_0F0F, 1'b0, 1'b0, 1'b1, 1'b0, 1'b0);
    queue_request(ACT_COMBINED, 32'hFF00_00FF, 1'b1, 1'b0, 1'b0, 1'b0, 1'b0);
    queue_request(ACT_TICK, '0, 1'b0, 1'b0, 1'b0, 1'b1, 1'b1);
    queue_request(ACT_INIT, '1, 1'b1, 1'b1, 1'b1, 1'b1, 1'b1);
    queue_request(ACT_TICK, '0, 1'b0, 1'b0, 1'b0, 1'b1, 1'b0);
    queue_request(ActUnusedLo, '1, 1'b1, 1'b1, 1'b1, 1'b1, 1'b1);
    queue_request(ActUnusedHi, '1, 1'b1, 1'b1, 1'b1, 1'b1, 1'b1);
    queue_request(ACT_TICK, '0, 1'b0, 1'b0, 1'b0, 1'b1, 1'b1);
    wait_until_drained();

    // Random traffic under a spread of settings, extremes included.
    run_phase(1'b1, '1, '0, 80);
    run_phase(1'b1, '1, '1, 80);
    run_phase(1'b1, 4'b0101, 4'b1010, 70);
    run_phase(1'b1, '0, '1, 50);
    run_phase(1'b0, '1, '1, 40);
    run_phase(1'b1, 4'($urandom), 4'($urandom), 80);
    run_phase(1'b1, 4'($urandom), 4'($urandom), 80);
    run_phase(1'b1, '1, 4'b0110, 70);

    $display("Summary: %0d requests over %0d register settings, %0d drive words checked.",
             requests_sent, settings_used, words_checked);
    $display("Summary: masked rotates, blink priority, init, disabled ticks, unused codes.");
    if (mismatch_count == 0) begin
      $display("PASSED: all results match");
    end else begin
      $display("FAILED: results differ");
    end
    $finish;
  end

  // Watchdog for a hung handshake or a drive word that never comes.
  initial begin
    #(TimeoutNs);
    $display("Timeout with %0d drive words still due.", drive_words_due.size());
    $display("FAILED: results differ");
    $finish;
  end

endmodule
